// File: rtl/core/sced_pkg.sv
// ----------------------------------------------------------------------------
// sced_pkg
// Shared types and constants of the seam cumulative energy block.
// ----------------------------------------------------------------------------
package sced_pkg;

  localparam int unsigned MaxColumns = 4096;
  localparam int unsigned ColW       = $clog2(MaxColumns);
  localparam int unsigned WidthW     = ColW + 1;
  localparam int unsigned EnergyW    = 16;
  localparam int unsigned AddrW      = 3;
  localparam int unsigned DataW      = 32;

  localparam logic [EnergyW-1:0]       MaxEnergy     = '1;
  localparam logic signed [WidthW-1:0] NoParent      = '1;
  localparam logic [WidthW-1:0]        RowWidthReset = WidthW'(MaxColumns);
  localparam logic [WidthW-1:0]        MaxWidth      = WidthW'(MaxColumns);
  localparam logic                     RegRowWidth   = 1'b0;

  typedef struct packed {
    logic [EnergyW-1:0] energy;
    logic               mark;
  } line_entry_t;

  typedef struct packed {
    logic            has_ul;
    logic            has_ur;
    logic [ColW-1:0] col;
    logic [ColW-1:0] ur_col;
  } col_info_t;

endpackage

// File: rtl/core/sced_pixel_if.sv
// ----------------------------------------------------------------------------
// sced_pixel_if
// Pixel item channel: energy, seam mark and first-row flag.
// ----------------------------------------------------------------------------
interface sced_pixel_if
  import sced_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [EnergyW-1:0] pixel_energy;
  logic               marked;
  logic               first_row;

  modport source (output valid, output pixel_energy, output marked, output first_row,
                  input ready);
  modport sink   (input valid, input pixel_energy, input marked, input first_row,
                  output ready);
endinterface

// File: rtl/core/sced_result_if.sv
// ----------------------------------------------------------------------------
// sced_result_if
// Result item channel: cumulative energy and parent column.
// ----------------------------------------------------------------------------
interface sced_result_if
  import sced_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [EnergyW-1:0]       cum_energy;
  logic signed [WidthW-1:0] parent_column;

  modport source (output valid, output cum_energy, output parent_column, input ready);
  modport sink   (input valid, input cum_energy, input parent_column, output ready);
endinterface

// File: rtl/core/seam_cumulative_energy_dp.sv
// ----------------------------------------------------------------------------
// seam_cumulative_energy_dp
// Stage 1 feeds the result register; one item per cycle unless results
// stall, set by the two-read line store and the output register. The result
// register decouples the sides: a new pixel is taken while a result waits
// if stage 1 is empty. Reset clears counters, handshake state and left
// parent (0xFFFF, marked); line store contents are undefined until written.
// ----------------------------------------------------------------------------
module seam_cumulative_energy_dp
  import sced_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  sced_pixel_if.sink       pix_i,
  sced_result_if.source    res_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic [WidthW-1:0]        width;
  col_info_t                col_in;
  logic                     accept;
  logic                     advance;

  logic                     s1_v_q;
  logic [EnergyW-1:0]       s1_energy_q;
  logic                     s1_mark_q;
  logic                     s1_first_q;
  col_info_t                s1_col_q;

  line_entry_t              left_q;
  line_entry_t              up, ur, wr_entry;
  logic [EnergyW-1:0]       cum;
  logic signed [WidthW-1:0] parent;

  logic                     out_v_q;
  logic [EnergyW-1:0]       out_cum_q;
  logic signed [WidthW-1:0] out_par_q;

  sced_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .width_o (width)
  );

  assign advance     = s1_v_q && (!out_v_q || res_o.ready);
  assign pix_i.ready = !s1_v_q || advance;
  assign accept      = pix_i.valid && pix_i.ready;

  sced_colctr u_colctr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .first_i  (pix_i.first_row),
    .width_i  (width),
    .col_o    (col_in)
  );

  assign wr_entry.energy = cum;
  assign wr_entry.mark   = s1_mark_q;

  sced_linestore u_linestore (
    .clk_i      (clk_i),
    .rd_en_i    (accept),
    .rd_addr0_i (col_in.col),
    .rd_addr1_i (col_in.ur_col),
    .wr_en_i    (advance),
    .wr_addr_i  (s1_col_q.col),
    .wr_data_i  (wr_entry),
    .rd_data0_o (up),
    .rd_data1_o (ur)
  );

  sced_select u_select (
    .left_i   (left_q),
    .up_i     (up),
    .ur_i     (ur),
    .col_i    (s1_col_q),
    .energy_i (s1_energy_q),
    .mark_i   (s1_mark_q),
    .first_i  (s1_first_q),
    .cum_o    (cum),
    .parent_o (parent)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      left_q  <= '{energy: MaxEnergy, mark: 1'b1};
    end else begin
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (advance) begin
        s1_v_q <= 1'b0;
      end
      if (advance) begin
        out_v_q <= 1'b1;
        left_q  <= up;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_energy_q <= pix_i.pixel_energy;
      s1_mark_q   <= pix_i.marked;
      s1_first_q  <= pix_i.first_row;
      s1_col_q    <= col_in;
    end
    if (advance) begin
      out_cum_q <= cum;
      out_par_q <= parent;
    end
  end

  assign res_o.valid         = out_v_q;
  assign res_o.cum_energy    = out_cum_q;
  assign res_o.parent_column = out_par_q;

endmodule

// File: rtl/core/sced_apb.sv
// ----------------------------------------------------------------------------
// sced_apb
// APB register file holding the row width; gives the clamped width.
// ----------------------------------------------------------------------------
module sced_apb
  import sced_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  output logic [WidthW-1:0] width_o
);

  logic [WidthW-1:0] width_q, width_d;
  logic              sel_width;

  assign pready    = 1'b1;
  assign sel_width = (paddr[AddrW-1] == RegRowWidth);

  always_comb begin
    width_d = width_q;
    if (psel && penable && pwrite && sel_width) begin
      width_d = pwdata[WidthW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= RowWidthReset;
    end else begin
      width_q <= width_d;
    end
  end

  assign prdata = sel_width ? DataW'(width_q) : '0;

  always_comb begin
    if (width_q == '0) begin
      width_o = WidthW'(1);
    end else if (width_q > MaxWidth) begin
      width_o = MaxWidth;
    end else begin
      width_o = width_q;
    end
  end

endmodule

// File: rtl/core/sced_colctr.sv
// ----------------------------------------------------------------------------
// sced_colctr
// Column counter: column of the incoming pixel, edge flags, row restart.
// ----------------------------------------------------------------------------
module sced_colctr
  import sced_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              first_i,
  input  logic [WidthW-1:0] width_i,
  output col_info_t         col_o
);

  logic [ColW-1:0]   cnt_q, cnt_d;
  logic              in_first_q;
  logic [ColW-1:0]   base;
  logic [ColW-1:0]   col;
  logic [WidthW-1:0] col_p1;

  always_comb begin
    base   = (first_i && !in_first_q) ? '0 : cnt_q;
    col    = ({1'b0, base} >= width_i) ? '0 : base;
    col_p1 = {1'b0, col} + WidthW'(1);
    col_o.col    = col;
    col_o.ur_col = col_p1[ColW-1:0];
    col_o.has_ul = (col != '0);
    col_o.has_ur = (col_p1 < width_i);
    cnt_d  = col_o.has_ur ? col_p1[ColW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      in_first_q <= 1'b0;
    end else if (accept_i) begin
      cnt_q      <= cnt_d;
      in_first_q <= first_i;
    end
  end

endmodule

// File: rtl/core/sced_linestore.sv
// ----------------------------------------------------------------------------
// sced_linestore
// Previous-row line store: one write port, two registered read ports,
// with write-to-read bypass for a write at the same edge.
// ----------------------------------------------------------------------------
module sced_linestore
  import sced_pkg::*;
(
  input  logic            clk_i,
  input  logic            rd_en_i,
  input  logic [ColW-1:0] rd_addr0_i,
  input  logic [ColW-1:0] rd_addr1_i,
  input  logic            wr_en_i,
  input  logic [ColW-1:0] wr_addr_i,
  input  line_entry_t     wr_data_i,
  output line_entry_t     rd_data0_o,
  output line_entry_t     rd_data1_o
);

  line_entry_t mem_q [MaxColumns];
  line_entry_t rd0_q, rd1_q, byp_q;
  logic        hit0_q, hit1_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd0_q  <= mem_q[rd_addr0_i];
      rd1_q  <= mem_q[rd_addr1_i];
      byp_q  <= wr_data_i;
      hit0_q <= wr_en_i && (wr_addr_i == rd_addr0_i);
      hit1_q <= wr_en_i && (wr_addr_i == rd_addr1_i);
    end
  end

  assign rd_data0_o = hit0_q ? byp_q : rd0_q;
  assign rd_data1_o = hit1_q ? byp_q : rd1_q;

endmodule

// File: rtl/core/sced_select.sv
// ----------------------------------------------------------------------------
// sced_select
// Parent selection: least unmarked parent, left wins ties, saturating add.
// ----------------------------------------------------------------------------
module sced_select
  import sced_pkg::*;
(
  input  line_entry_t              left_i,
  input  line_entry_t              up_i,
  input  line_entry_t              ur_i,
  input  col_info_t                col_i,
  input  logic [EnergyW-1:0]       energy_i,
  input  logic                     mark_i,
  input  logic                     first_i,
  output logic [EnergyW-1:0]       cum_o,
  output logic signed [WidthW-1:0] parent_o
);

  logic [EnergyW-1:0]       best;
  logic signed [WidthW-1:0] par;
  logic                     found;
  logic [EnergyW:0]         sum;

  always_comb begin
    best  = MaxEnergy;
    par   = NoParent;
    found = 1'b0;
    if (!first_i && !mark_i) begin
      if (col_i.has_ul && !left_i.mark && (left_i.energy < best)) begin
        best  = left_i.energy;
        par   = {1'b0, col_i.col} - WidthW'(1);
        found = 1'b1;
      end
      if (!up_i.mark && (up_i.energy < best)) begin
        best  = up_i.energy;
        par   = {1'b0, col_i.col};
        found = 1'b1;
      end
      if (col_i.has_ur && !ur_i.mark && (ur_i.energy < best)) begin
        best  = ur_i.energy;
        par   = {1'b0, col_i.ur_col};
        found = 1'b1;
      end
    end
    sum = {1'b0, best} + {1'b0, energy_i};
    if (first_i) begin
      cum_o    = energy_i;
      parent_o = NoParent;
    end else if (found) begin
      cum_o    = sum[EnergyW] ? MaxEnergy : sum[EnergyW-1:0];
      parent_o = par;
    end else begin
      cum_o    = MaxEnergy;
      parent_o = NoParent;
    end
  end

endmodule
